// ----- rtl/fbpa_pkg.sv -----
// shared types, constants and codes of the fixed block pool allocator
package fbpa_pkg;

    // pool geometry (word size is a power of two)
    localparam int MAX_BLOCKS = 1024;
    localparam int WORD_BYTES = 8;
    localparam int WORD_SH    = $clog2(WORD_BYTES);

    localparam int ADDR_W = 32;
    localparam int BLK_W  = 16;
    localparam int STR_W  = 17;
    localparam int IDX_W  = $clog2(MAX_BLOCKS + 1);
    localparam int Q_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int RAM_AW = Q_W;
    localparam int REM_W  = STR_W + Q_W;
    localparam int LIM_W  = STR_W + IDX_W;
    localparam int CNT_W  = $clog2(Q_W + 1);

    localparam logic [IDX_W-1:0] NULL_IDX  = IDX_W'(MAX_BLOCKS);
    localparam logic [IDX_W-1:0] MAX_CNT   = IDX_W'(MAX_BLOCKS);
    localparam logic [STR_W-1:0] WORD_STR  = STR_W'(WORD_BYTES);
    localparam logic [STR_W-1:0] WORD_RND  = STR_W'(WORD_BYTES - 1);
    localparam logic [STR_W-1:0] STR_MASK  = ~STR_W'(WORD_BYTES - 1);

    // operation codes
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_BLOCK = 2'd1;
    localparam logic [1:0] CFG_POOL  = 2'd2;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [REM_W-1:0] dividend;
        logic [STR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
        logic           rem_zero;
    } div_rsp_t;

endpackage

// ----- rtl/fixed_block_pool_allocator.sv -----
// top level of the fixed block pool allocator: control, pool registers and free-list head
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+------------------------------
//  in      | in_valid, in_stall, operation,            | in_valid high, in_stall low
//          | freed_address                             |
//  out     | out_valid, out_stall, status,             | out_valid high, out_stall low
//          | block_address                             |
//  config  | wr_en, wr_index, wr_data                  | wr_en high
//
// one item at a time; every item gives one result in an output register
// steps of each operation, the result load last:
// alloc: head check, link memory read, head update, result load
// free: offset and range check, bit-serial divider; a zero address goes straight to the result
// init: prep, limit, count by the divider, span, link chain; a full pool skips the divider
// the next item is taken while a result still waits under out_stall
// reset leaves an empty pool with stride of one word; the link memory is not cleared
module fixed_block_pool_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     operation,
    input  logic [fbpa_pkg::ADDR_W-1:0]    freed_address,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [fbpa_pkg::ADDR_W-1:0]    block_address,
    input  logic                           wr_en,
    input  logic [1:0]                     wr_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    wr_data
);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_INIT_PREP = 13'b0000000000010,
        S_INIT_LIM  = 13'b0000000000100,
        S_INIT_CNT  = 13'b0000000001000,
        S_INIT_DIV  = 13'b0000000010000,
        S_INIT_SPAN = 13'b0000000100000,
        S_INIT_LINK = 13'b0000001000000,
        S_ALLOC_RD  = 13'b0000010000000,
        S_ALLOC_WB  = 13'b0000100000000,
        S_FREE_OFF  = 13'b0001000000000,
        S_FREE_CHK  = 13'b0010000000000,
        S_FREE_DIV  = 13'b0100000000000,
        S_RESP      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [fbpa_pkg::ADDR_W-1:0] base_cfg_reg, base_cfg_next;
    logic [fbpa_pkg::BLK_W-1:0]  blk_cfg_reg, blk_cfg_next;
    logic [fbpa_pkg::ADDR_W-1:0] pool_cfg_reg, pool_cfg_next;

    // pool state
    logic [fbpa_pkg::IDX_W-1:0]  head_reg, head_next;
    logic [fbpa_pkg::IDX_W-1:0]  count_reg, count_next;
    logic [fbpa_pkg::ADDR_W-1:0] ab_reg, ab_next;
    logic [fbpa_pkg::STR_W-1:0]  stride_reg, stride_next;
    logic [fbpa_pkg::LIM_W-1:0]  span_reg, span_next;
    logic                        out_valid_reg, out_valid_next;

    // working registers
    logic [fbpa_pkg::ADDR_W:0]   total_reg, total_next;
    logic [fbpa_pkg::LIM_W-1:0]  lim_reg, lim_next;
    logic [fbpa_pkg::IDX_W-1:0]  link_reg, link_next;
    logic [fbpa_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [fbpa_pkg::ADDR_W-1:0] off_reg, off_next;
    logic                        ge_reg, ge_next;
    logic [fbpa_pkg::LIM_W-1:0]  prod_reg, prod_next;
    logic [1:0]                  res_status_reg, res_status_next;
    logic [fbpa_pkg::ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [1:0]                  out_status_reg, out_status_next;
    logic [fbpa_pkg::ADDR_W-1:0] out_addr_reg, out_addr_next;

    // link memory port
    logic                        ram_we;
    logic [fbpa_pkg::RAM_AW-1:0] ram_waddr;
    logic [fbpa_pkg::IDX_W-1:0]  ram_wdata;
    logic [fbpa_pkg::RAM_AW-1:0] ram_raddr;
    logic [fbpa_pkg::IDX_W-1:0]  ram_rdata;

    fbpa_pkg::div_req_t div_req;
    fbpa_pkg::div_rsp_t div_rsp;

    // init setup terms
    logic [fbpa_pkg::WORD_SH-1:0] pad;
    logic [fbpa_pkg::ADDR_W:0]    ab_wide;
    logic [fbpa_pkg::ADDR_W:0]    room;
    logic [fbpa_pkg::ADDR_W:0]    avail;
    logic [fbpa_pkg::STR_W-1:0]   blk_min;
    logic [fbpa_pkg::IDX_W-1:0]   link_inc;

    fbpa_link_ram u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fbpa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall = (state_reg != S_IDLE);

    // configuration writes
    always_comb
    begin
        base_cfg_next = base_cfg_reg;
        blk_cfg_next  = blk_cfg_reg;
        pool_cfg_next = pool_cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                fbpa_pkg::CFG_BASE:  base_cfg_next = wr_data;
                fbpa_pkg::CFG_BLOCK: blk_cfg_next  = wr_data[fbpa_pkg::BLK_W-1:0];
                fbpa_pkg::CFG_POOL:  pool_cfg_next = wr_data;
                default:             ;
            endcase
        end
    end

    // main control
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        ab_next         = ab_reg;
        stride_next     = stride_reg;
        span_next       = span_reg;
        total_next      = total_reg;
        lim_next        = lim_reg;
        link_next       = link_reg;
        addr_next       = addr_reg;
        off_next        = off_reg;
        ge_next         = ge_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_valid_next  = out_valid_reg && out_stall;

        ram_we    = 1'b0;
        ram_waddr = link_reg[fbpa_pkg::RAM_AW-1:0];
        ram_wdata = fbpa_pkg::NULL_IDX;
        ram_raddr = head_reg[fbpa_pkg::RAM_AW-1:0];

        div_req.start    = 1'b0;
        div_req.dividend = fbpa_pkg::REM_W'(off_reg);
        div_req.divisor  = stride_reg;

        // word padding of the base and room left below the top of the address space
        pad     = '0 - base_cfg_reg[fbpa_pkg::WORD_SH-1:0];
        ab_wide = {1'b0, base_cfg_reg} + (fbpa_pkg::ADDR_W + 1)'(pad);
        room    = {1'b1, {fbpa_pkg::ADDR_W{1'b0}}} - ab_wide;
        avail   = (pool_cfg_reg > fbpa_pkg::ADDR_W'(pad))
                  ? {1'b0, pool_cfg_reg} - (fbpa_pkg::ADDR_W + 1)'(pad) : '0;
        blk_min = (fbpa_pkg::STR_W'(blk_cfg_reg) < fbpa_pkg::WORD_STR)
                  ? fbpa_pkg::WORD_STR : fbpa_pkg::STR_W'(blk_cfg_reg);
        link_inc = link_reg + 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next       = freed_address;
                    res_status_next = fbpa_pkg::ST_OK;
                    res_addr_next   = '0;
                    case (operation)
                        fbpa_pkg::OP_INIT:  state_next = S_INIT_PREP;
                        fbpa_pkg::OP_ALLOC: state_next = S_ALLOC_RD;
                        fbpa_pkg::OP_FREE:  state_next = S_FREE_OFF;
                        default:            state_next = S_RESP;
                    endcase
                end
            end

            S_INIT_PREP:
            begin
                // stride: at least one word, rounded up to a word multiple
                stride_next = (blk_min + fbpa_pkg::WORD_RND) & fbpa_pkg::STR_MASK;
                if (ab_wide[fbpa_pkg::ADDR_W])
                begin
                    ab_next    = '0;
                    total_next = '0;
                end
                else
                begin
                    ab_next    = ab_wide[fbpa_pkg::ADDR_W-1:0];
                    total_next = (avail > room) ? room : avail;
                end
                state_next = S_INIT_LIM;
            end

            S_INIT_LIM:
            begin
                lim_next   = fbpa_pkg::LIM_W'(stride_reg) * fbpa_pkg::LIM_W'(fbpa_pkg::MAX_BLOCKS);
                state_next = S_INIT_CNT;
            end

            S_INIT_CNT:
            begin
                // a full pool needs no divide
                if (total_reg >= (fbpa_pkg::ADDR_W + 1)'(lim_reg))
                begin
                    count_next = fbpa_pkg::MAX_CNT;
                    state_next = S_INIT_SPAN;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = fbpa_pkg::REM_W'(total_reg);
                    state_next       = S_INIT_DIV;
                end
            end

            S_INIT_DIV:
            begin
                if (div_rsp.done)
                begin
                    count_next = fbpa_pkg::IDX_W'(div_rsp.quotient);
                    state_next = S_INIT_SPAN;
                end
            end

            S_INIT_SPAN:
            begin
                span_next  = fbpa_pkg::LIM_W'(count_reg) * fbpa_pkg::LIM_W'(stride_reg);
                head_next  = (count_reg != '0) ? '0 : fbpa_pkg::NULL_IDX;
                link_next  = '0;
                state_next = S_INIT_LINK;
            end

            S_INIT_LINK:
            begin
                // ascending chain, last block points to null
                if (link_reg == count_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = (link_inc < count_reg) ? link_inc : fbpa_pkg::NULL_IDX;
                    link_next = link_inc;
                end
            end

            S_ALLOC_RD:
            begin
                if (head_reg < count_reg)
                begin
                    prod_next  = fbpa_pkg::LIM_W'(head_reg) * fbpa_pkg::LIM_W'(stride_reg);
                    state_next = S_ALLOC_WB;
                end
                else
                begin
                    res_status_next = fbpa_pkg::ST_EMPTY;
                    state_next      = S_RESP;
                end
            end

            S_ALLOC_WB:
            begin
                // pop: link of the old head becomes the new head
                head_next     = ram_rdata;
                res_addr_next = ab_reg + fbpa_pkg::ADDR_W'(prod_reg);
                state_next    = S_RESP;
            end

            S_FREE_OFF:
            begin
                if (addr_reg == '0)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    ge_next    = (addr_reg >= ab_reg);
                    off_next   = addr_reg - ab_reg;
                    state_next = S_FREE_CHK;
                end
            end

            S_FREE_CHK:
            begin
                if (!ge_reg || (fbpa_pkg::LIM_W'(off_reg) >= span_reg)
                    || (off_reg >= fbpa_pkg::ADDR_W'(span_reg)
                        && fbpa_pkg::LIM_W > fbpa_pkg::ADDR_W)
                    || (fbpa_pkg::ADDR_W > fbpa_pkg::LIM_W
                        && (off_reg >> fbpa_pkg::LIM_W) != '0))
                begin
                    res_status_next = fbpa_pkg::ST_BAD;
                    state_next      = S_RESP;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_FREE_DIV;
                end
            end

            S_FREE_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.rem_zero)
                    begin
                        // push onto the head
                        ram_we    = 1'b1;
                        ram_waddr = div_rsp.quotient;
                        ram_wdata = head_reg;
                        head_next = fbpa_pkg::IDX_W'(div_rsp.quotient);
                    end
                    else
                    begin
                        res_status_next = fbpa_pkg::ST_BAD;
                    end
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_cfg_reg  <= '0;
            blk_cfg_reg   <= fbpa_pkg::BLK_W'(8);
            pool_cfg_reg  <= '0;
            head_reg      <= fbpa_pkg::NULL_IDX;
            count_reg     <= '0;
            ab_reg        <= '0;
            stride_reg    <= fbpa_pkg::WORD_STR;
            span_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_cfg_reg  <= base_cfg_next;
            blk_cfg_reg   <= blk_cfg_next;
            pool_cfg_reg  <= pool_cfg_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            ab_reg        <= ab_next;
            stride_reg    <= stride_next;
            span_reg      <= span_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg      <= total_next;
        lim_reg        <= lim_next;
        link_reg       <= link_next;
        addr_reg       <= addr_next;
        off_reg        <= off_next;
        ge_reg         <= ge_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign block_address = out_addr_reg;

endmodule

// ----- rtl/fbpa_link_ram.sv -----
// next-link memory of the free list, one write and one registered read port
module fbpa_link_ram (
    input  logic                          clk,
    input  logic                          we,
    input  logic [fbpa_pkg::RAM_AW-1:0]   waddr,
    input  logic [fbpa_pkg::IDX_W-1:0]    wdata,
    input  logic [fbpa_pkg::RAM_AW-1:0]   raddr,
    output logic [fbpa_pkg::IDX_W-1:0]    rdata
);

    logic [fbpa_pkg::IDX_W-1:0] mem [fbpa_pkg::MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/fbpa_div.sv -----
// restoring divider, one quotient bit per cycle, quotient below 2**Q_W
module fbpa_div (
    input  logic                clk,
    input  logic                rst_n,
    input  fbpa_pkg::div_req_t  req,
    output fbpa_pkg::div_rsp_t  rsp
);

    logic [fbpa_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [fbpa_pkg::REM_W-1:0] sh_reg, sh_next;
    logic [fbpa_pkg::Q_W-1:0]   quo_reg, quo_next;
    logic [fbpa_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic                       fits;

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        fits      = (rem_reg >= sh_reg);
        if (req.start)
        begin
            rem_next  = req.dividend;
            sh_next   = fbpa_pkg::REM_W'(req.divisor) << (fbpa_pkg::Q_W - 1);
            quo_next  = '0;
            cnt_next  = fbpa_pkg::CNT_W'(fbpa_pkg::Q_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // subtract the shifted divisor where it fits
            if (fits)
            begin
                rem_next = rem_reg - sh_reg;
            end
            quo_next = fbpa_pkg::Q_W'({quo_reg, fits});
            sh_next  = sh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.rem_zero = (rem_reg == '0);

endmodule
